/* hdl/tonc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tonc_pkg
// Shared types and constants for the triangle outward normal core.
// ----------------------------------------------------------------------------
package tonc_pkg;

	localparam int COORD_W   = 32;           // Q16.16 vertex coordinate
	localparam int EDGE_W    = COORD_W + 1;  // vertex difference
	localparam int SUM_W     = COORD_W + 2;  // sum of three vertices
	localparam int PROD_W    = 2 * EDGE_W;   // edge product
	localparam int CROSS_W   = PROD_W + 1;   // cross product component
	localparam int BLEN_W    = 7;            // bit length of a cross magnitude
	localparam int SM_W      = 31;           // scaled magnitude
	localparam int SQ_W      = 64;           // sum of squares
	localparam int ROOT_W    = SQ_W / 2;     // integer square root
	localparam int SQRT_STEPS = ROOT_W;      // one root bit per stage
	localparam int Q_W       = SM_W;         // quotient bits
	localparam int DIV_STEPS = Q_W;          // one quotient bit per stage
	localparam int NUM_W     = 2 * Q_W;      // dividend width
	localparam int FRAC_W    = 30;           // Q2.30 fraction bits
	localparam int NRM_W     = 32;           // output component
	localparam int DOTP_W    = SUM_W + NRM_W;
	localparam int DOT_W     = DOTP_W + 2;

	typedef struct packed {
		logic signed [COORD_W-1:0] a_x;
		logic signed [COORD_W-1:0] a_y;
		logic signed [COORD_W-1:0] a_z;
		logic signed [COORD_W-1:0] b_x;
		logic signed [COORD_W-1:0] b_y;
		logic signed [COORD_W-1:0] b_z;
		logic signed [COORD_W-1:0] c_x;
		logic signed [COORD_W-1:0] c_y;
		logic signed [COORD_W-1:0] c_z;
	} vert_t;

	typedef struct packed {
		logic signed [NRM_W-1:0] normal_x;
		logic signed [NRM_W-1:0] normal_y;
		logic signed [NRM_W-1:0] normal_z;
		logic                    degenerate;
		logic                    flipped;
	} result_t;

	// Data riding alongside the square root pipeline
	typedef struct packed {
		logic [2:0][SUM_W-1:0] vsum;
		logic [2:0]            neg;
		logic [2:0][SM_W-1:0]  sm;
		logic                  degen;
	} sqrt_side_t;

	// Data riding alongside the divider pipeline
	typedef struct packed {
		logic [2:0][SUM_W-1:0] vsum;
		logic [2:0]            neg;
		logic                  degen;
	} div_side_t;

endpackage

/* hdl/triangle_outward_normal_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_outward_normal_core
// Unit normal of a Q16.16 triangle in Q2.30, oriented away from the origin.
// ----------------------------------------------------------------------------
// One triangle is taken in every clock cycle: busy stays low and each
// transfer on start produces exactly one result strobed on done. The path
// holds 78 register stages: 9 front stages for edges, cross product and
// scaling, 33 square root stages, 1 dividend stage, 32 divider stages
// and 3 stages for sign, orientation and output. The receiver cannot
// stall, so results must be taken in the cycle they appear.
// ----------------------------------------------------------------------------
module triangle_outward_normal_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tonc_pkg::vert_t   vert,
	output logic              done,
	output tonc_pkg::result_t result
);

	localparam int EW = tonc_pkg::EDGE_W;
	localparam int SW = tonc_pkg::SUM_W;
	localparam int PW = tonc_pkg::PROD_W;
	localparam int CW = tonc_pkg::CROSS_W;
	localparam int MW = tonc_pkg::SM_W;
	localparam int NW = tonc_pkg::NRM_W;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic vld_s10, vld_s11, vld_s12;

	tonc_pkg::vert_t            vert_s1;
	logic signed [EW-1:0]       e_s2 [3];
	logic signed [EW-1:0]       f_s2 [3];
	logic [2:0][SW-1:0]         vsum_s2, vsum_s3, vsum_s4, vsum_s5, vsum_s6, vsum_s7;
	logic [2:0][SW-1:0]         vsum_s8, vsum_s9;
	logic signed [PW-1:0]       prod_s3 [6];
	logic signed [CW-1:0]       cross_s4 [3];
	logic [2:0][CW-1:0]         mag_s5, mag_s6;
	logic [2:0]                 neg_s5, neg_s6, neg_s7, neg_s8, neg_s9;
	logic [tonc_pkg::BLEN_W-1:0] blen_s6;
	logic                       degen_s6, degen_s7, degen_s8, degen_s9;
	logic [2:0][MW-1:0]         sm_s7, sm_s8, sm_s9;
	logic [2*MW-1:0]            sqr_s8 [3];
	logic [tonc_pkg::SQ_W-1:0]  sq_s9;

	logic                        sq_vld;
	logic [tonc_pkg::ROOT_W-1:0] len;
	tonc_pkg::sqrt_side_t        sq_side_in, sq_side;

	logic [2:0][tonc_pkg::NUM_W-1:0] num_s10;
	logic [tonc_pkg::ROOT_W-1:0]     den_s10;
	tonc_pkg::div_side_t             side_s10;

	logic                          dv_vld;
	logic [2:0][tonc_pkg::Q_W-1:0] quo;
	tonc_pkg::div_side_t           dv_side;

	logic signed [NW-1:0]          nrm_s11 [3];
	logic [2:0][SW-1:0]            vsum_s11;
	logic                          degen_s11, degen_s12;
	logic signed [tonc_pkg::DOTP_W-1:0] dotp_s12 [3];
	logic signed [NW-1:0]          nrm_s12 [3];
	logic signed [tonc_pkg::DOT_W-1:0]  dot;

	logic [CW-1:0]               mag_or;
	logic [tonc_pkg::BLEN_W-1:0] blen;
	logic [2:0][MW-1:0]          sm_nx;

	assign busy = 1'b0;

	// Find the bit length of the largest cross magnitude
	assign mag_or = mag_s5[0] | mag_s5[1] | mag_s5[2];
	always_comb begin
		blen = '0;
		for (int i = 0; i < CW; i++) begin
			if (mag_or[i]) begin
				blen = tonc_pkg::BLEN_W'(i + 1);
			end
		end
	end

	// Normalise the magnitudes so that the largest lies in [2^30, 2^31)
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (blen_s6 > tonc_pkg::BLEN_W'(MW)) begin
				sm_nx[k] = MW'(mag_s6[k] >> (blen_s6 - tonc_pkg::BLEN_W'(MW)));
			end else begin
				sm_nx[k] = MW'(mag_s6[k] << (tonc_pkg::BLEN_W'(MW) - blen_s6));
			end
		end
	end

	// Advance valid bits of the front and back stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			done    <= 1'b0;
		end else begin
			vld_s1  <= start & ~busy;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= sq_vld;
			vld_s11 <= dv_vld;
			vld_s12 <= vld_s11;
			done    <= vld_s12;
		end
	end

	// Front stages: edges, vertex sums, products, cross product, magnitudes, scaling, squares
	always_ff @(posedge clk) begin
		vert_s1 <= vert;

		e_s2[0] <= EW'(vert_s1.c_x) - EW'(vert_s1.b_x);
		e_s2[1] <= EW'(vert_s1.c_y) - EW'(vert_s1.b_y);
		e_s2[2] <= EW'(vert_s1.c_z) - EW'(vert_s1.b_z);
		f_s2[0] <= EW'(vert_s1.a_x) - EW'(vert_s1.b_x);
		f_s2[1] <= EW'(vert_s1.a_y) - EW'(vert_s1.b_y);
		f_s2[2] <= EW'(vert_s1.a_z) - EW'(vert_s1.b_z);
		vsum_s2[0] <= SW'(vert_s1.a_x) + SW'(vert_s1.b_x) + SW'(vert_s1.c_x);
		vsum_s2[1] <= SW'(vert_s1.a_y) + SW'(vert_s1.b_y) + SW'(vert_s1.c_y);
		vsum_s2[2] <= SW'(vert_s1.a_z) + SW'(vert_s1.b_z) + SW'(vert_s1.c_z);

		prod_s3[0] <= PW'(e_s2[1]) * PW'(f_s2[2]);
		prod_s3[1] <= PW'(e_s2[2]) * PW'(f_s2[1]);
		prod_s3[2] <= PW'(e_s2[2]) * PW'(f_s2[0]);
		prod_s3[3] <= PW'(e_s2[0]) * PW'(f_s2[2]);
		prod_s3[4] <= PW'(e_s2[0]) * PW'(f_s2[1]);
		prod_s3[5] <= PW'(e_s2[1]) * PW'(f_s2[0]);
		vsum_s3    <= vsum_s2;

		for (int k = 0; k < 3; k++) begin
			cross_s4[k] <= CW'(prod_s3[2*k]) - CW'(prod_s3[2*k+1]);
		end
		vsum_s4 <= vsum_s3;

		for (int k = 0; k < 3; k++) begin
			neg_s5[k] <= cross_s4[k][CW-1];
			mag_s5[k] <= cross_s4[k][CW-1] ? CW'(-cross_s4[k]) : CW'(cross_s4[k]);
		end
		vsum_s5 <= vsum_s4;

		mag_s6   <= mag_s5;
		blen_s6  <= blen;
		degen_s6 <= (mag_or == '0);
		neg_s6   <= neg_s5;
		vsum_s6  <= vsum_s5;

		sm_s7    <= sm_nx;
		degen_s7 <= degen_s6;
		neg_s7   <= neg_s6;
		vsum_s7  <= vsum_s6;

		for (int k = 0; k < 3; k++) begin
			sqr_s8[k] <= (2*MW)'(sm_s7[k]) * (2*MW)'(sm_s7[k]);
		end
		sm_s8    <= sm_s7;
		degen_s8 <= degen_s7;
		neg_s8   <= neg_s7;
		vsum_s8  <= vsum_s7;

		sq_s9    <= tonc_pkg::SQ_W'(sqr_s8[0]) + tonc_pkg::SQ_W'(sqr_s8[1])
		          + tonc_pkg::SQ_W'(sqr_s8[2]);
		sm_s9    <= sm_s8;
		degen_s9 <= degen_s8;
		neg_s9   <= neg_s8;
		vsum_s9  <= vsum_s8;
	end

	// Square root of the sum of squares
	assign sq_side_in = '{vsum: vsum_s9, neg: neg_s9, sm: sm_s9, degen: degen_s9};

	tonc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s9),
		.num      (sq_s9),
		.in_side  (sq_side_in),
		.out_vld  (sq_vld),
		.root     (len),
		.out_side (sq_side)
	);

	// Form rounded dividends: sm * 2^30 + len / 2
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			num_s10[k] <= {sq_side.sm[k], tonc_pkg::FRAC_W'(0)}
			            + tonc_pkg::NUM_W'(len >> 1);
		end
		den_s10  <= len;
		side_s10 <= '{vsum: sq_side.vsum, neg: sq_side.neg, degen: sq_side.degen};
	end

	tonc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s10),
		.n        (num_s10),
		.d        (den_s10),
		.in_side  (side_s10),
		.out_vld  (dv_vld),
		.q        (quo),
		.out_side (dv_side)
	);

	// Back stages: restore signs, dot with vertex sum, orient and drop degenerate
	assign dot = tonc_pkg::DOT_W'(dotp_s12[0]) + tonc_pkg::DOT_W'(dotp_s12[1])
	           + tonc_pkg::DOT_W'(dotp_s12[2]);

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			nrm_s11[k] <= dv_side.neg[k] ? -NW'(quo[k]) : NW'(quo[k]);
		end
		vsum_s11  <= dv_side.vsum;
		degen_s11 <= dv_side.degen;

		for (int k = 0; k < 3; k++) begin
			dotp_s12[k] <= tonc_pkg::DOTP_W'($signed(vsum_s11[k]))
			             * tonc_pkg::DOTP_W'(nrm_s11[k]);
			nrm_s12[k]  <= nrm_s11[k];
		end
		degen_s12 <= degen_s11;

		if (degen_s12) begin
			result.normal_x   <= '0;
			result.normal_y   <= '0;
			result.normal_z   <= '0;
			result.degenerate <= 1'b1;
			result.flipped    <= 1'b0;
		end else if (dot[tonc_pkg::DOT_W-1]) begin
			result.normal_x   <= -nrm_s12[0];
			result.normal_y   <= -nrm_s12[1];
			result.normal_z   <= -nrm_s12[2];
			result.degenerate <= 1'b0;
			result.flipped    <= 1'b1;
		end else begin
			result.normal_x   <= nrm_s12[0];
			result.normal_y   <= nrm_s12[1];
			result.normal_z   <= nrm_s12[2];
			result.degenerate <= 1'b0;
			result.flipped    <= 1'b0;
		end
	end

endmodule

/* hdl/tonc_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tonc_sqrt
// Pipelined integer square root, one result bit resolved per stage.
// ----------------------------------------------------------------------------
module tonc_sqrt (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_vld,
	input  logic [tonc_pkg::SQ_W-1:0]        num,
	input  tonc_pkg::sqrt_side_t             in_side,
	output logic                             out_vld,
	output logic [tonc_pkg::ROOT_W-1:0]      root,
	output tonc_pkg::sqrt_side_t             out_side
);

	localparam int N = tonc_pkg::SQRT_STEPS;
	localparam int W = tonc_pkg::SQ_W;

	logic [N:0]          vld_s;
	logic [W-1:0]        num_s  [N+1];
	logic [W-1:0]        res_s  [N+1];
	tonc_pkg::sqrt_side_t side_s [N+1];
	logic [W-1:0]        num_nx [N];
	logic [W-1:0]        res_nx [N];

	// Resolve one root bit per stage: trial subtract of res + 4^k
	always_comb begin
		logic [W-1:0] bit_v;
		logic [W-1:0] trial;
		for (int j = 0; j < N; j++) begin
			bit_v = W'(1) << (W - 2 - 2 * j);
			trial = res_s[j] + bit_v;
			if (num_s[j] >= trial) begin
				num_nx[j] = num_s[j] - trial;
				res_nx[j] = (res_s[j] >> 1) + bit_v;
			end else begin
				num_nx[j] = num_s[j];
				res_nx[j] = res_s[j] >> 1;
			end
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[N-1:0], in_vld};
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		num_s[0]  <= num;
		res_s[0]  <= '0;
		side_s[0] <= in_side;
		for (int j = 0; j < N; j++) begin
			num_s[j+1]  <= num_nx[j];
			res_s[j+1]  <= res_nx[j];
			side_s[j+1] <= side_s[j];
		end
	end

	assign out_vld  = vld_s[N];
	assign root     = res_s[N][tonc_pkg::ROOT_W-1:0];
	assign out_side = side_s[N];

endmodule

/* hdl/tonc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tonc_div
// Three-lane pipelined restoring divider with a shared divisor, one quotient
// bit per stage. The quotient is known to fit in Q_W bits.
// ----------------------------------------------------------------------------
module tonc_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_vld,
	input  logic [2:0][tonc_pkg::NUM_W-1:0]       n,
	input  logic [tonc_pkg::ROOT_W-1:0]           d,
	input  tonc_pkg::div_side_t                   in_side,
	output logic                                  out_vld,
	output logic [2:0][tonc_pkg::Q_W-1:0]         q,
	output tonc_pkg::div_side_t                   out_side
);

	localparam int N  = tonc_pkg::DIV_STEPS;
	localparam int QW = tonc_pkg::Q_W;
	localparam int DW = tonc_pkg::ROOT_W;
	localparam int NW = tonc_pkg::NUM_W;

	logic [N:0]                   vld_s;
	logic [2:0][DW-1:0]           rem_s  [N+1];
	logic [2:0][NW-1:0]           num_s  [N+1];
	logic [2:0][QW-1:0]           quo_s  [N+1];
	logic [DW-1:0]                den_s  [N+1];
	tonc_pkg::div_side_t          side_s [N+1];
	logic [2:0][DW-1:0]           rem_nx [N];
	logic [2:0][QW-1:0]           quo_nx [N];

	// Shift in the next dividend bit and subtract the divisor where it fits
	always_comb begin
		logic [DW:0] trial;
		for (int j = 0; j < N; j++) begin
			for (int k = 0; k < 3; k++) begin
				trial        = {rem_s[j][k], num_s[j][k][N-1-j]};
				quo_nx[j][k] = quo_s[j][k];
				if (trial >= {1'b0, den_s[j]}) begin
					rem_nx[j][k]       = DW'(trial - {1'b0, den_s[j]});
					quo_nx[j][k][N-1-j] = 1'b1;
				end else begin
					rem_nx[j][k] = trial[DW-1:0];
				end
			end
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[N-1:0], in_vld};
		end
	end

	// Advance payload; the top dividend bits start as the remainder
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			rem_s[0][k] <= DW'(n[k][NW-1:QW]);
		end
		num_s[0]  <= n;
		quo_s[0]  <= '0;
		den_s[0]  <= d;
		side_s[0] <= in_side;
		for (int j = 0; j < N; j++) begin
			rem_s[j+1]  <= rem_nx[j];
			num_s[j+1]  <= num_s[j];
			quo_s[j+1]  <= quo_nx[j];
			den_s[j+1]  <= den_s[j];
			side_s[j+1] <= side_s[j];
		end
	end

	assign out_vld  = vld_s[N];
	assign q        = quo_s[N];
	assign out_side = side_s[N];

endmodule
